### rtl/core/bsfd_pkg.sv
// package for the byte stuffed frame decoder: word types, codes and constants
package bsfd_pkg;

    // payload buffer depth default
    localparam int BUFFER_DEPTH_DEF = 256;

    // reset values of the marker registers
    localparam logic [7:0] START_MARKER_RST  = 8'h7d;
    localparam logic [7:0] STOP_MARKER_RST   = 8'h7c;
    localparam logic [7:0] ESCAPE_MARKER_RST = 8'h7e;

    // value folded into the byte after an escape
    localparam logic [7:0] ESC_XOR = 8'h20;

    // configuration register indexes
    localparam logic [1:0] CFG_START_MARKER  = 2'd0;
    localparam logic [1:0] CFG_STOP_MARKER   = 2'd1;
    localparam logic [1:0] CFG_ESCAPE_MARKER = 2'd2;

    // opcodes
    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // parser states
    typedef enum logic [2:0] {
        ST_START   = 3'd0,
        ST_LENGTH  = 3'd1,
        ST_PAYLOAD = 3'd2,
        ST_ESCAPED = 3'd3,
        ST_STOP    = 3'd4
    } t_parser_state;

    // input word
    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_item;

    // output word
    typedef struct packed {
        logic       frame_done;
        logic [7:0] frame_length;
        logic [7:0] read_data;
    } t_out_item;

endpackage

### rtl/core/byte_stuffed_frame_decoder_unit.sv
// byte stuffed frame decoder: parser, payload buffer and output stage
//
// Input words carry an opcode, a received byte and a read index. A receive
// word advances the frame parser (start marker, length byte, escaped payload,
// stop marker) and writes payload bytes into the buffer ram; a read word
// fetches one stored byte. Every input word gives exactly one output word
// with frame_done, the current length register and the read byte (0 on
// receive words and on reads beyond the buffer).
// Each accepted word passes the ram's registered read and middle stage, then
// the output register. Throughput is one word per cycle unless the receiver
// stalls; the parser state sits in flip-flops and the buffer takes one write
// or one read per word through its single pair of ports. When the receiver
// stalls, the output word holds, the middle stage fills, and o_in_stall
// rises; nothing is lost or repeated. The user must write marker registers
// (configuration channel, always ready) only while idle; it is not enforced.
// Reset (synchronous, active low) empties the pipeline, sets the parser to
// wait for a start marker, clears length and write index and restores the
// default markers. The buffer has no reset; it needs no clearing pass.
module byte_stuffed_frame_decoder_unit
    import bsfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    // output channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [8:0] DEPTH_LIM = 9'(BUFFER_DEPTH);

    // marker registers
    logic [7:0] r_start_marker;
    logic [7:0] r_stop_marker;
    logic [7:0] r_escape_marker;

    // parser state
    t_parser_state r_state, n_state;
    logic [7:0]    r_wi, n_wi;
    logic [7:0]    r_len, n_len;

    // pipeline
    logic       r_s1_valid;
    logic       r_s1_done;
    logic [7:0] r_s1_len;
    logic       r_s1_rd;
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic          w_accept;
    logic          w_recv;
    logic          w_out_blocked;
    logic          w_s1_adv;
    logic [7:0]    w_b;
    logic          w_stray;
    t_parser_state w_cur;
    logic [7:0]    w_wi;
    logic [7:0]    w_wi_inc;
    logic [7:0]    w_store_byte;
    logic          w_store;
    logic          w_we;
    logic          w_done;
    logic          w_rd_in_range;
    logic          w_re;
    logic [7:0]    w_ram_rdata;

    // handshake
    assign w_out_blocked = r_out_valid && i_out_stall;
    assign w_s1_adv      = r_s1_valid && !w_out_blocked;
    assign o_in_stall    = r_s1_valid && w_out_blocked;
    assign w_accept      = i_in_valid && !o_in_stall;
    assign w_recv        = w_accept && (i_in_item.opcode == OP_RECEIVE);
    assign o_cfg_ready   = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker  <= START_MARKER_RST;
            r_stop_marker   <= STOP_MARKER_RST;
            r_escape_marker <= ESCAPE_MARKER_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_MARKER:  r_start_marker  <= i_cfg_data;
                CFG_STOP_MARKER:   r_stop_marker   <= i_cfg_data;
                CFG_ESCAPE_MARKER: r_escape_marker <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stray stop marker restarts the parser before the byte is examined
    assign w_b          = i_in_item.rx_byte;
    assign w_stray      = (r_state != ST_STOP) && (w_b == r_stop_marker);
    assign w_cur        = w_stray ? ST_START : r_state;
    assign w_wi         = w_stray ? 8'd0 : r_wi;
    assign w_wi_inc     = w_wi + 8'd1;
    assign w_store_byte = (w_cur == ST_ESCAPED) ? (w_b ^ ESC_XOR) : w_b;

    // parser next state
    always_comb begin
        n_state = w_cur;
        n_wi    = w_wi;
        n_len   = r_len;
        unique case (w_cur)
            ST_LENGTH: begin
                n_len   = w_b;
                n_wi    = 8'd0;
                n_state = (w_b == 8'd0) ? ST_STOP : ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                if (w_b == r_escape_marker) begin
                    n_state = ST_ESCAPED;
                end else begin
                    n_wi    = w_wi_inc;
                    n_state = (w_wi_inc == r_len) ? ST_STOP : ST_PAYLOAD;
                end
            end
            ST_ESCAPED: begin
                n_wi    = w_wi_inc;
                n_state = (w_wi_inc == r_len) ? ST_STOP : ST_PAYLOAD;
            end
            ST_STOP: begin
                if (w_b == r_stop_marker) begin
                    n_state = ST_START;
                    n_wi    = 8'd0;
                end
            end
            default: begin
                n_state = ST_START;
                if (w_b == r_start_marker) begin
                    n_state = ST_LENGTH;
                    n_wi    = 8'd0;
                end
            end
        endcase
    end

    // parser outputs: buffer write and frame completion
    always_comb begin
        w_store = 1'b0;
        w_done  = 1'b0;
        unique case (w_cur)
            ST_PAYLOAD: w_store = (w_b != r_escape_marker);
            ST_ESCAPED: w_store = 1'b1;
            ST_STOP:    w_done  = (w_b == r_stop_marker);
            default: ;
        endcase
    end

    assign w_we = w_recv && w_store && ({1'b0, w_wi} < DEPTH_LIM);

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
            r_wi    <= 8'd0;
            r_len   <= 8'd0;
        end else if (w_recv) begin
            r_state <= n_state;
            r_wi    <= n_wi;
            r_len   <= n_len;
        end
    end

    // payload buffer
    assign w_rd_in_range = ({1'b0, i_in_item.read_index} < DEPTH_LIM);
    assign w_re = w_accept && (i_in_item.opcode == OP_READ) && w_rd_in_range;

    bsfd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wi[AW-1:0]),
        .i_wdata (w_store_byte),
        .i_re    (w_re),
        .i_raddr (i_in_item.read_index[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // middle stage, waits for the ram read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_done <= w_recv && w_done;
            r_s1_len  <= w_recv ? n_len : r_len;
            r_s1_rd   <= w_re;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_item.frame_done   <= r_s1_done;
            r_out_item.frame_length <= r_s1_len;
            r_out_item.read_data    <= r_s1_rd ? w_ram_rdata : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/core/bsfd_ram.sv
// generic single write port ram with registered read
module bsfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
